@@ sv/trs_pkg.sv @@
package trs_pkg;

    localparam int XW   = 15;
    localparam int YW   = 11;
    localparam int RW   = 9;
    localparam int CW   = 10;
    localparam int DYW  = 11;
    localparam int DXW  = XW + 1;
    localparam int P1W  = XW + DYW + 1;
    localparam int P2W  = DXW + DYW + 1;
    localparam int NUMW = P2W + 1;
    localparam int FRAC = 4;
    localparam int DENW = DYW + FRAC;
    localparam int QW   = 11;
    localparam int MAGW = DENW + QW;

    localparam int SETUP_STAGES = 3;
    localparam int STAGES       = SETUP_STAGES + QW + 1;

    localparam int VERT_W = XW + YW;
    localparam int IN_W   = 88;
    localparam int OUT_W  = 24;

    typedef struct packed {
        logic            hit;
        logic            neg;
        logic [MAGW-1:0] mag;
        logic [DENW-1:0] den;
    } div_in_t;

    typedef struct packed {
        logic          hit;
        logic          neg;
        logic [QW-1:0] quo;
    } lane_res_t;

endpackage

@@ sv/trs_edge_setup.sv @@
module trs_edge_setup (
    input  logic                               clk,
    input  logic [trs_pkg::SETUP_STAGES-1:0]   en,
    input  logic signed [trs_pkg::XW-1:0]      x0,
    input  logic signed [trs_pkg::YW-1:0]      y0,
    input  logic signed [trs_pkg::XW-1:0]      x1,
    input  logic signed [trs_pkg::YW-1:0]      y1,
    input  logic [trs_pkg::RW-1:0]             row,
    input  logic                               row_ok,
    output trs_pkg::div_in_t                   dout
);

    logic                              swap;
    logic signed [trs_pkg::XW-1:0]     xa_c;
    logic signed [trs_pkg::XW-1:0]     xb_c;
    logic signed [trs_pkg::YW:0]       ya_e;
    logic signed [trs_pkg::YW:0]       yb_e;
    logic signed [trs_pkg::YW:0]       r_s;
    logic signed [trs_pkg::YW:0]       dy_c;
    logic signed [trs_pkg::YW:0]       t_c;
    logic signed [trs_pkg::DXW-1:0]    dx_c;
    logic                              hit_c;

    logic signed [trs_pkg::XW-1:0]     xa_reg;
    logic [trs_pkg::DYW-1:0]           dy0_reg;
    logic [trs_pkg::DYW-1:0]           t_reg;
    logic signed [trs_pkg::DXW-1:0]    dx_reg;
    logic                              hit0_reg;

    logic signed [trs_pkg::P1W-1:0]    p1_reg;
    logic signed [trs_pkg::P2W-1:0]    p2_reg;
    logic [trs_pkg::DYW-1:0]           dy1_reg;
    logic                              hit1_reg;

    logic signed [trs_pkg::NUMW-1:0]   num_c;
    logic signed [trs_pkg::NUMW-1:0]   abs_c;
    trs_pkg::div_in_t                  dout_reg;

    // orient the edge from its upper to its lower vertex
    assign swap = y0 > y1;
    assign xa_c = swap ? x1 : x0;
    assign xb_c = swap ? x0 : x1;
    assign ya_e = swap ? {y1[trs_pkg::YW-1], y1} : {y0[trs_pkg::YW-1], y0};
    assign yb_e = swap ? {y0[trs_pkg::YW-1], y0} : {y1[trs_pkg::YW-1], y1};
    assign r_s  = $signed({{(trs_pkg::YW + 1 - trs_pkg::RW){1'b0}}, row});
    assign dy_c = yb_e - ya_e;
    assign t_c  = r_s - ya_e;
    assign dx_c = {xb_c[trs_pkg::XW-1], xb_c} - {xa_c[trs_pkg::XW-1], xa_c};
    assign hit_c = row_ok && (y0 != y1) && (r_s >= ya_e) && (r_s <= yb_e);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xa_reg   <= xa_c;
            dy0_reg  <= dy_c[trs_pkg::DYW-1:0];
            t_reg    <= t_c[trs_pkg::DYW-1:0];
            dx_reg   <= dx_c;
            hit0_reg <= hit_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p1_reg   <= trs_pkg::P1W'(xa_reg) * trs_pkg::P1W'($signed({1'b0, dy0_reg}));
            p2_reg   <= trs_pkg::P2W'(dx_reg) * trs_pkg::P2W'($signed({1'b0, t_reg}));
            dy1_reg  <= dy0_reg;
            hit1_reg <= hit0_reg;
        end
    end

    assign num_c = {{(trs_pkg::NUMW - trs_pkg::P1W){p1_reg[trs_pkg::P1W-1]}}, p1_reg}
                 + {{(trs_pkg::NUMW - trs_pkg::P2W){p2_reg[trs_pkg::P2W-1]}}, p2_reg};
    assign abs_c = num_c[trs_pkg::NUMW-1] ? -num_c : num_c;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            dout_reg.hit <= hit1_reg;
            dout_reg.neg <= num_c[trs_pkg::NUMW-1];
            dout_reg.mag <= abs_c[trs_pkg::MAGW-1:0];
            dout_reg.den <= {dy1_reg, {trs_pkg::FRAC{1'b0}}};
        end
    end

    assign dout = dout_reg;

endmodule

@@ sv/trs_div_pipe.sv @@
module trs_div_pipe (
    input  logic                     clk,
    input  logic [trs_pkg::QW-1:0]   en,
    input  trs_pkg::div_in_t         din,
    output trs_pkg::lane_res_t       dout
);

    logic [trs_pkg::MAGW-1:0] rem_reg [trs_pkg::QW-1];
    logic [trs_pkg::DENW-1:0] den_reg [trs_pkg::QW-1];
    logic [trs_pkg::QW-1:0]   quo_reg [trs_pkg::QW];
    logic                     neg_reg [trs_pkg::QW];
    logic                     hit_reg [trs_pkg::QW];

    for (genvar i = 0; i < trs_pkg::QW; i++)
    begin : g_stage
        localparam int B = trs_pkg::QW - 1 - i;

        logic [trs_pkg::MAGW-1:0] rem_in;
        logic [trs_pkg::DENW-1:0] den_in;
        logic [trs_pkg::QW-1:0]   quo_in;
        logic                     neg_in;
        logic                     hit_in;
        logic [trs_pkg::MAGW-1:0] dsh;
        logic                     ge;

        if (i == 0)
        begin : g_first
            assign rem_in = din.mag;
            assign den_in = din.den;
            assign quo_in = '0;
            assign neg_in = din.neg;
            assign hit_in = din.hit;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign neg_in = neg_reg[i-1];
            assign hit_in = hit_reg[i-1];
        end

        assign dsh = trs_pkg::MAGW'(den_in) << B;
        assign ge  = rem_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                quo_reg[i] <= quo_in | (trs_pkg::QW'(ge) << B);
                neg_reg[i] <= neg_in;
                hit_reg[i] <= hit_in;
            end
        end

        if (i < trs_pkg::QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    rem_reg[i] <= ge ? rem_in - dsh : rem_in;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign dout.hit = hit_reg[trs_pkg::QW-1];
    assign dout.neg = neg_reg[trs_pkg::QW-1];
    assign dout.quo = quo_reg[trs_pkg::QW-1];

endmodule

@@ sv/trs_merge.sv @@
module trs_merge #(
    parameter int SCREEN_COLS = 640
) (
    input  logic                            clk,
    input  logic                            en,
    input  trs_pkg::lane_res_t [2:0]        lanes,
    output logic [trs_pkg::CW-1:0]          span_start,
    output logic [trs_pkg::CW-1:0]          span_end,
    output logic                            span_empty
);

    localparam logic [trs_pkg::QW-1:0] COLS = trs_pkg::QW'(SCREEN_COLS);

    logic [trs_pkg::QW-1:0] xc [3];
    logic [trs_pkg::QW-1:0] lo;
    logic [trs_pkg::QW-1:0] hi;
    logic                   any;

    logic [trs_pkg::CW-1:0] start_reg;
    logic [trs_pkg::CW-1:0] end_reg;
    logic                   empty_reg;

    always_comb
    begin
        lo  = '1;
        hi  = '0;
        any = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            // clamp to the screen: a negative x lands on column zero
            if (lanes[k].neg)
                xc[k] = '0;
            else if (lanes[k].quo > COLS)
                xc[k] = COLS;
            else
                xc[k] = lanes[k].quo;
            if (lanes[k].hit)
            begin
                any = 1'b1;
                if (xc[k] < lo)
                    lo = xc[k];
                if (xc[k] > hi)
                    hi = xc[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            start_reg <= any ? lo[trs_pkg::CW-1:0] : COLS[trs_pkg::CW-1:0];
            end_reg   <= any ? hi[trs_pkg::CW-1:0] : '0;
            empty_reg <= !any;
        end
    end

    assign span_start = start_reg;
    assign span_end   = end_reg;
    assign span_empty = empty_reg;

endmodule

@@ sv/triangle_row_span_core.sv @@
// Triangle row span: three vertices and a screen row in, the covered column span out.
// Input channel s_*: one transfer carries ax, ay, bx, by, cx, cy and row.
// Output channel m_*: one transfer per input transfer, in order, with span_start and
// span_end in m_tdata and the empty flag in m_tuser.
// Each edge runs in a lane of its own: orient, two multiplies, sum and magnitude,
// then an 11-stage restoring divider giving one quotient bit per stage. A final
// stage clamps the three lane results and takes their minimum and maximum.
// Throughput: one transfer per cycle, set by the divider taking one bit per stage, as
// long as a stall has not filled every stage from the input up to the output.
// Reset: all stage valid bits clear, nothing is in flight and s_tready is high.
// Stall: when m_tready is low the result holds on m_tdata and m_tuser; items behind
// it keep advancing into empty stages, and s_tready falls only once every stage
// from the input up to the output holds an item.
module triangle_row_span_core #(
    parameter int SCREEN_ROWS = 480,
    parameter int SCREEN_COLS = 640
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [trs_pkg::IN_W-1:0]    s_tdata,  // ax, ay, bx, by, cx, cy, row, zero fill
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [trs_pkg::OUT_W-1:0]   m_tdata,  // span_start, span_end, zero fill
    output logic                        m_tuser   // span_empty
);

    logic [trs_pkg::STAGES-1:0]      valid_reg;
    logic [trs_pkg::STAGES-1:0]      valid_next;
    logic [trs_pkg::STAGES-1:0]      en;

    logic signed [trs_pkg::XW-1:0]   vx [3];
    logic signed [trs_pkg::YW-1:0]   vy [3];
    logic [trs_pkg::RW-1:0]          row;
    logic                            row_ok;

    trs_pkg::div_in_t                div_in [3];
    trs_pkg::lane_res_t [2:0]        lane_res;

    logic [trs_pkg::CW-1:0]          span_start;
    logic [trs_pkg::CW-1:0]          span_end;
    logic                            span_empty;

    for (genvar k = 0; k < trs_pkg::STAGES; k++)
    begin : g_en
        assign en[k] = m_tready | ~(&valid_reg[trs_pkg::STAGES-1:k]);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
            valid_next[0] = s_tvalid;
        for (int k = 1; k < trs_pkg::STAGES; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[trs_pkg::STAGES-1];

    for (genvar v = 0; v < 3; v++)
    begin : g_vert
        assign vx[v] = s_tdata[v*trs_pkg::VERT_W +: trs_pkg::XW];
        assign vy[v] = s_tdata[v*trs_pkg::VERT_W + trs_pkg::XW +: trs_pkg::YW];
    end

    assign row    = s_tdata[3*trs_pkg::VERT_W +: trs_pkg::RW];
    assign row_ok = {2'b00, row} < (trs_pkg::RW + 2)'(SCREEN_ROWS);

    for (genvar e = 0; e < 3; e++)
    begin : g_lane
        trs_edge_setup u_setup (
            .clk    (clk),
            .en     (en[trs_pkg::SETUP_STAGES-1:0]),
            .x0     (vx[e]),
            .y0     (vy[e]),
            .x1     (vx[(e + 1) % 3]),
            .y1     (vy[(e + 1) % 3]),
            .row    (row),
            .row_ok (row_ok),
            .dout   (div_in[e])
        );

        trs_div_pipe u_div (
            .clk  (clk),
            .en   (en[trs_pkg::SETUP_STAGES +: trs_pkg::QW]),
            .din  (div_in[e]),
            .dout (lane_res[e])
        );
    end

    trs_merge #(
        .SCREEN_COLS (SCREEN_COLS)
    ) u_merge (
        .clk        (clk),
        .en         (en[trs_pkg::STAGES-1]),
        .lanes      (lane_res),
        .span_start (span_start),
        .span_end   (span_end),
        .span_empty (span_empty)
    );

    assign m_tdata = {{(trs_pkg::OUT_W - 2*trs_pkg::CW){1'b0}}, span_end, span_start};
    assign m_tuser = span_empty;

endmodule

@@ tb/trs_span_checker.sv @@
`timescale 1ns / 1ps

module trs_span_checker #(
    parameter int SCREEN_ROWS = 480,
    parameter int SCREEN_COLS = 640
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [trs_pkg::IN_W-1:0]   s_tdata,   // ax, ay, bx, by, cx, cy, row, zero fill
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [trs_pkg::OUT_W-1:0]  m_tdata,   // span_start, span_end, zero fill
    input  logic                       m_tuser,   // span_empty
    input  logic                       drained,
    output int                         pending,
    output int                         fails,
    output int                         spans_checked,
    output int                         empty_rows
);

    typedef struct packed {
        logic [trs_pkg::CW-1:0] lo_col;
        logic [trs_pkg::CW-1:0] hi_col;
        logic                   empty;
    } span_t;

    span_t awaited_spans[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        fails++;
    endtask

    // Column where one edge crosses the row, clamped; 0 when the edge misses it.
    function automatic bit edge_column(input longint x0, input longint y0, input longint x1,
                                       input longint y1, input longint r,
                                       output longint col);
        longint xa;
        longint ya;
        longint xb;
        longint yb;
        longint dy;
        col = 0;
        if (y0 == y1)
            return 1'b0;
        if (y0 < y1)
        begin
            xa = x0; ya = y0; xb = x1; yb = y1;
        end
        else
        begin
            xa = x1; ya = y1; xb = x0; yb = y0;
        end
        if (r < ya || r > yb)
            return 1'b0;
        dy  = yb - ya;
        col = (xa * dy + (r - ya) * (xb - xa)) / (16 * dy);
        if (col < 0)
            col = 0;
        else if (col > SCREEN_COLS)
            col = SCREEN_COLS;
        return 1'b1;
    endfunction

    function automatic span_t predict_span(input logic [trs_pkg::IN_W-1:0] q);
        longint vx[3];
        longint vy[3];
        longint r;
        longint col;
        longint lo;
        longint hi;
        bit     any;
        span_t  sp;
        lo  = 0;
        hi  = 0;
        any = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = longint'($signed(q[i*trs_pkg::VERT_W +: trs_pkg::XW]));
            vy[i] = longint'($signed(q[i*trs_pkg::VERT_W+trs_pkg::XW +: trs_pkg::YW]));
        end
        r = longint'(q[3*trs_pkg::VERT_W +: trs_pkg::RW]);
        if (r < SCREEN_ROWS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (edge_column(vx[i], vy[i], vx[(i+1)%3], vy[(i+1)%3], r, col))
                begin
                    if (!any || col < lo)
                        lo = col;
                    if (!any || col > hi)
                        hi = col;
                    any = 1'b1;
                end
            end
        end
        if (any)
        begin
            sp.lo_col = trs_pkg::CW'(lo);
            sp.hi_col = trs_pkg::CW'(hi);
            sp.empty  = 1'b0;
        end
        else
        begin
            sp.lo_col = trs_pkg::CW'(SCREEN_COLS);
            sp.hi_col = '0;
            sp.empty  = 1'b1;
        end
        return sp;
    endfunction

    always @(posedge clk)
    begin
        span_t want;
        logic [trs_pkg::CW-1:0] got_lo;
        logic [trs_pkg::CW-1:0] got_hi;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                awaited_spans.push_back(predict_span(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got_lo = m_tdata[trs_pkg::CW-1:0];
                got_hi = m_tdata[2*trs_pkg::CW-1:trs_pkg::CW];
                if (awaited_spans.size() == 0)
                    report_mismatch($sformatf("span %0d..%0d empty=%b with no query waiting",
                                              got_lo, got_hi, m_tuser));
                else
                begin
                    want = awaited_spans.pop_front();
                    spans_checked++;
                    if (want.empty)
                        empty_rows++;
                    if (got_lo !== want.lo_col)
                        report_mismatch($sformatf("span_start %0d, expected %0d",
                                                  got_lo, want.lo_col));
                    if (got_hi !== want.hi_col)
                        report_mismatch($sformatf("span_end %0d, expected %0d",
                                                  got_hi, want.hi_col));
                    if (m_tuser !== want.empty)
                        report_mismatch($sformatf("span_empty %b, expected %b",
                                                  m_tuser, want.empty));
                end
            end
            if (drained && awaited_spans.size() != 0)
            begin
                report_mismatch($sformatf("%0d spans never returned", awaited_spans.size()));
                awaited_spans.delete();
            end
        end
        pending <= awaited_spans.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [trs_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [trs_pkg::OUT_W-1:0]  m_tdata;
    logic                       m_tuser;
    logic                       drained = 1'b0;

    int pending;
    int fails;
    int spans_checked;
    int empty_rows;
    int queries_sent = 0;
    int cycles = 0;

    bit tx_gaps = 1'b1;
    bit rx_steady = 1'b0;
    int hold_req = 0;
    int hold_taken = 0;

    always #1 clk = ~clk;

    triangle_row_span_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    trs_span_checker u_span_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .drained       (drained),
        .pending       (pending),
        .fails         (fails),
        .spans_checked (spans_checked),
        .empty_rows    (empty_rows)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [trs_pkg::IN_W-1:0] pack_query(input int ax, input int ay,
                                                            input int bx, input int by,
                                                            input int cx, input int cy,
                                                            input int row);
        logic [trs_pkg::IN_W-1:0] q;
        q = '0;
        q[0*trs_pkg::VERT_W +: trs_pkg::XW]             = trs_pkg::XW'(ax);
        q[0*trs_pkg::VERT_W+trs_pkg::XW +: trs_pkg::YW] = trs_pkg::YW'(ay);
        q[1*trs_pkg::VERT_W +: trs_pkg::XW]             = trs_pkg::XW'(bx);
        q[1*trs_pkg::VERT_W+trs_pkg::XW +: trs_pkg::YW] = trs_pkg::YW'(by);
        q[2*trs_pkg::VERT_W +: trs_pkg::XW]             = trs_pkg::XW'(cx);
        q[2*trs_pkg::VERT_W+trs_pkg::XW +: trs_pkg::YW] = trs_pkg::YW'(cy);
        q[3*trs_pkg::VERT_W +: trs_pkg::RW]             = trs_pkg::RW'(row);
        return q;
    endfunction

    function automatic logic [trs_pkg::IN_W-1:0] random_query();
        int xs[3];
        int ys[3];
        int pick;
        int top_row;
        int bot_row;
        int r;
        pick = $urandom_range(99);
        if (pick < 15)
            return pack_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
        for (int i = 0; i < 3; i++)
        begin
            xs[i] = int'($urandom_range(720 * 16)) - 40 * 16;
            ys[i] = int'($urandom_range(540)) - 30;
        end
        if (pick >= 85)
        begin
            // small triangle: short edges, fractional steps
            for (int i = 1; i < 3; i++)
            begin
                xs[i] = xs[0] + int'($urandom_range(64)) - 32;
                ys[i] = ys[0] + int'($urandom_range(6));
            end
        end
        if (pick < 25)
            ys[1] = ys[0];
        if (pick < 20)
            ys[2] = ys[0];
        top_row = ys[0];
        bot_row = ys[0];
        for (int i = 1; i < 3; i++)
        begin
            if (ys[i] < top_row)
                top_row = ys[i];
            if (ys[i] > bot_row)
                bot_row = ys[i];
        end
        if (top_row < 0)
            top_row = 0;
        if (bot_row > 479)
            bot_row = 479;
        if (pick % 7 == 0 && ys[pick % 3] >= 0)
            r = ys[pick % 3];
        else if (pick % 4 != 0 && top_row <= bot_row)
            r = $urandom_range(bot_row, top_row);
        else
            r = $urandom_range(511);
        return pack_query(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], r);
    endfunction

    task automatic send_query(input logic [trs_pkg::IN_W-1:0] q);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        do @(posedge clk); while (!s_tready);
        queries_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random back-pressure, steady stretches, and a long hold-off on request
    initial
    begin
        int run_len;
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_taken != hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_taken = hold_req;
            end
            else
            begin
                m_tready <= 1'b1;
                run_len = rx_steady ? 1 : $urandom_range(1, 12);
                repeat (run_len) @(posedge clk);
                gap = rx_steady ? 0 : pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_query(pack_query(10*16, 0, 100*16, 0, 50*16, 100, 0));
        send_query(pack_query(10*16, 0, 100*16, 0, 50*16, 100, 50));
        send_query(pack_query(10*16, 0, 100*16, 0, 50*16, 100, 100));
        send_query(pack_query(10*16, 0, 100*16, 0, 50*16, 100, 101));
        send_query(pack_query(10*16, 0, 100*16, 0, 50*16, 100, 1));
        send_query(pack_query(30*16, 200, 90*16, 200, 60*16, 200, 200));
        send_query(pack_query(0, -1024, 300*16, 1023, 600*16, 0, 480));
        send_query(pack_query(0, -1024, 300*16, 1023, 600*16, 0, 511));
        send_query(pack_query(-16384, -1024, 16383, 1023, -16384, 1023, 0));
        send_query(pack_query(-16384, -1024, 16383, 1023, -16384, 1023, 479));
        send_query(pack_query(16383, 1023, 16383, 1023, 16383, 1023, 511));
        send_query(pack_query(-16384, -1024, -16384, -1024, -16384, -1024, 0));
        send_query(pack_query(640*16, 0, 640*16, 479, 0, 0, 10));
        send_query(pack_query(-100*16, 0, 800*16, 300, -50*16, 300, 150));
        send_query(pack_query(-8, 0, -8, 10, 40, 10, 5));
        send_query(pack_query(17, 3, 1000, 7, 333, 470, 4));
        send_query(pack_query(300*16, 400, 100*16, 400, 200*16, 20, 20));
        send_query(pack_query(5*16+15, -1024, 5*16+15, 1023, 6*16, 0, 479));

        tx_gaps   = 1'b0;
        rx_steady = 1'b1;
        repeat (150) send_query(random_query());

        // hold the output for a long stretch while the input keeps offering transfers
        rx_steady = 1'b0;
        hold_req++;
        repeat (60) send_query(random_query());
        wait_drained();

        tx_gaps = 1'b1;
        repeat (330) send_query(random_query());
        wait_drained();

        repeat (2 * trs_pkg::STAGES) @(posedge clk);
        drained <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Applied %0d triangle/row queries, %0d spans compared, %0d of them empty.",
                 queries_sent, spans_checked, empty_rows);
        $display("Included edge cases, random back-pressure and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
